// ----- rtl/dow_pkg.sv -----
// Shared types, calendar constants and month tables for the date offset block.
// No dependencies; used by dow_alu, dow_cal and date_offset_weekday.
`default_nettype none

package dow_pkg;

    typedef struct packed {
        logic neg;
        logic zero;
    } alu_flags_t;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_MAY = 4'd5;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_JUL = 4'd7;
    localparam logic [3:0] MON_AUG = 4'd8;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    localparam logic [13:0] DEF_YEAR   = 14'd1900;
    localparam int          DAYS_400Y  = 146097;
    localparam int          YEARS_400  = 400;
    localparam int          CENTURY    = 100;
    localparam int          WEEK_DAYS  = 7;
    localparam int          YMOD_W     = 9;
    localparam logic [8:0]  YMOD_MAX   = 9'd399;
    localparam logic [4:0]  FEB_LIMIT  = 5'd29;
    localparam logic [4:0]  FEB_COMMON = 5'd28;
    localparam logic [4:0]  LEN_SHORT  = 5'd30;
    localparam logic [4:0]  LEN_LONG   = 5'd31;

    // Length of a month other than February; zero for codes outside 1..12.
    function automatic logic [4:0] base_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
            MON_JAN, MON_MAR, MON_MAY, MON_JUL,
            MON_AUG, MON_OCT, MON_DEC, MON_FEB: len = LEN_LONG;
            default:                            len = 5'd0;
        endcase
        return len;
    endfunction

    // Day limit used to check an incoming date; February always allows 29.
    function automatic logic [4:0] mon_limit(input logic [3:0] m);
        logic [4:0] len;
        if (m == MON_FEB)
            len = FEB_LIMIT;
        else
            len = base_len(m);
        return len;
    endfunction

    // 26*(m+1)/10 - 1, with January and February counted as months 13 and 14.
    function automatic logic [5:0] zeller_mterm(input logic [3:0] m);
        logic [5:0] t;
        case (m)
            MON_JAN: t = 6'd35;
            MON_FEB: t = 6'd38;
            MON_MAR: t = 6'd9;
            MON_APR: t = 6'd12;
            MON_MAY: t = 6'd14;
            MON_JUN: t = 6'd17;
            MON_JUL: t = 6'd19;
            MON_AUG: t = 6'd22;
            MON_SEP: t = 6'd25;
            MON_OCT: t = 6'd27;
            MON_NOV: t = 6'd30;
            MON_DEC: t = 6'd32;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dow_alu.sv -----
// Shared add/subtract unit with sign and zero flags.
// Depends on dow_pkg for the flag struct.
`default_nettype none

module dow_alu #(
    parameter int W = 20
) (
    input  logic [W-1:0]        a,
    input  logic [W-1:0]        b,
    input  logic                sub,
    output logic [W-1:0]        res,
    output dow_pkg::alu_flags_t flags
);

    logic [W-1:0] b_op;

    assign b_op       = sub ? ~b : b;
    assign res        = a + b_op + W'(sub);
    assign flags.neg  = res[W-1];
    assign flags.zero = (res == '0);

endmodule

`default_nettype wire

// ----- rtl/dow_cal.sv -----
// Month length and leap flag from the month and the year taken modulo 400.
// Depends on dow_pkg for month codes and lengths.
`default_nettype none

module dow_cal (
    input  logic [3:0] month,
    input  logic [8:0] ymod,
    output logic [4:0] mlen,
    output logic       leap
);

    assign leap = (ymod[1:0] == 2'b00)
               && (ymod != 9'(dow_pkg::CENTURY))
               && (ymod != 9'(2 * dow_pkg::CENTURY))
               && (ymod != 9'(3 * dow_pkg::CENTURY));

    always_comb
    begin
        if (month == dow_pkg::MON_FEB)
            mlen = leap ? dow_pkg::FEB_LIMIT : dow_pkg::FEB_COMMON;
        else
            mlen = dow_pkg::base_len(month);
    end

endmodule

`default_nettype wire

// ----- rtl/date_offset_weekday.sv -----
// Top level: date check, day offset, month walk and weekday sequencer.
// Depends on dow_pkg, dow_alu and dow_cal.
`default_nettype none

// Adds a signed day offset to a Gregorian date and reports the result date,
// its leap flag and its weekday (0 = Sunday). A date with year 0, a month
// outside 1..12, day 0 or a day past the month limit (February allows 29)
// is replaced by 1900-01-01 first. An item is taken when start is high and
// busy is low; busy then stays high until the result is out. The result
// appears for one cycle with done high and must be captured then. The day,
// year-modulo and weekday sums run through one shared adder, one step per
// cycle; the year, month and quotient counters step on their own. The year
// reduction modulo 400 and the divisions by 100 and by 7 in the weekday sum
// are done by repeated subtraction. The time an item takes grows with the
// start year, the 400-year cycles skipped, the months walked and the two
// quotients; the month walk dominates.
module date_offset_weekday #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [13:0]                   year_in,
    input  logic [3:0]                    month_in,
    input  logic [4:0]                    day_in,
    input  logic signed [OFFSET_BITS-1:0] day_offset,
    output logic                          busy,
    output logic                          done,
    output logic signed [14:0]            year_out,
    output logic [3:0]                    month_out,
    output logic [4:0]                    day_out,
    output logic                          leap_flag,
    output logic [2:0]                    weekday
);

    localparam int W = ((OFFSET_BITS > 18) ? OFFSET_BITS : 18) + 2;

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_YMOD = 17'h00002,
        S_OFFS = 17'h00004,
        S_CYC  = 17'h00008,
        S_WALK = 17'h00010,
        S_ZADJ = 17'h00020,
        S_ZABS = 17'h00040,
        S_DIV  = 17'h00080,
        S_P1   = 17'h00100,
        S_P2   = 17'h00200,
        S_P3   = 17'h00400,
        S_PNEG = 17'h00800,
        S_PM   = 17'h01000,
        S_PD   = 17'h02000,
        S_WABS = 17'h04000,
        S_MOD  = 17'h08000,
        S_DONE = 17'h10000
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    logic [W-1:0]  y_reg, y_next;
    logic [3:0]    m_reg, m_next;
    logic [W-1:0]  d_reg, d_next;
    logic [8:0]    ymod_reg, ymod_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [7:0]    rem_reg, rem_next;
    logic          sgn_reg, sgn_next;
    logic [W-1:0]  off_reg, off_next;

    logic [14:0]   yo_reg, yo_next;
    logic [3:0]    mo_reg, mo_next;
    logic [4:0]    do_reg, do_next;
    logic          leap_reg, leap_next;
    logic [2:0]    wd_reg, wd_next;

    logic [W-1:0]        alu_a, alu_b, alu_res;
    logic                alu_sub;
    dow_pkg::alu_flags_t alu_flags;

    logic [3:0] cal_m;
    logic [8:0] cal_ymod;
    logic [4:0] cal_len;
    logic       cal_leap;

    logic       d_pos;
    logic [3:0] m_prev;
    logic [8:0] ymod_prev, ymod_succ;
    logic       walk_back;
    logic [4:0] in_lim;
    logic       in_valid;
    logic [2:0] wd_fix;

    dow_alu #(
        .W (W)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .res   (alu_res),
        .flags (alu_flags)
    );

    dow_cal u_cal (
        .month (cal_m),
        .ymod  (cal_ymod),
        .mlen  (cal_len),
        .leap  (cal_leap)
    );

    assign d_pos     = !d_reg[W-1] && (d_reg != '0);
    assign m_prev    = (m_reg == dow_pkg::MON_JAN) ? dow_pkg::MON_DEC : m_reg - 4'd1;
    assign ymod_prev = (ymod_reg == 9'd0) ? dow_pkg::YMOD_MAX : ymod_reg - 9'd1;
    assign ymod_succ = (ymod_reg == dow_pkg::YMOD_MAX) ? 9'd0 : ymod_reg + 9'd1;
    assign walk_back = (state_reg == S_WALK) && !d_pos;

    // The backward step borrows the length of the month before.
    assign cal_m    = walk_back ? m_prev : m_reg;
    assign cal_ymod = (walk_back && (m_reg == dow_pkg::MON_JAN)) ? ymod_prev : ymod_reg;

    assign in_lim   = dow_pkg::mon_limit(month_in);
    assign in_valid = (year_in != 14'd0) && (in_lim != 5'd0)
                   && (day_in != 5'd0) && (day_in <= in_lim);

    assign wd_fix = (sgn_reg && (rem_reg[2:0] != 3'd0))
                  ? 3'(dow_pkg::WEEK_DAYS) - rem_reg[2:0]
                  : rem_reg[2:0];

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        y_next     = y_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        ymod_next  = ymod_reg;
        acc_next   = acc_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        sgn_next   = sgn_reg;
        off_next   = off_reg;
        yo_next    = yo_reg;
        mo_next    = mo_reg;
        do_next    = do_reg;
        leap_next  = leap_reg;
        wd_next    = wd_reg;
        alu_a      = acc_reg;
        alu_b      = '0;
        alu_sub    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    y_next   = in_valid ? W'(year_in) : W'(dow_pkg::DEF_YEAR);
                    acc_next = in_valid ? W'(year_in) : W'(dow_pkg::DEF_YEAR);
                    m_next   = in_valid ? month_in : dow_pkg::MON_JAN;
                    d_next   = in_valid ? W'(day_in) : W'(1);
                    off_next = {{(W - OFFSET_BITS){day_offset[OFFSET_BITS-1]}}, day_offset};
                    state_next = S_YMOD;
                end
            end
            S_YMOD:
            begin
                // Reduce the start year modulo 400 by repeated subtraction.
                alu_a   = acc_reg;
                alu_b   = W'(dow_pkg::YEARS_400);
                alu_sub = 1'b1;
                if (!alu_flags.neg)
                    acc_next = alu_res;
                else
                begin
                    ymod_next  = acc_reg[8:0];
                    state_next = S_OFFS;
                end
            end
            S_OFFS:
            begin
                alu_a      = d_reg;
                alu_b      = off_reg;
                d_next     = alu_res;
                state_next = S_CYC;
            end
            S_CYC:
            begin
                // Skip whole 400-year cycles; the year mod 400 holds.
                alu_a = d_reg;
                alu_b = W'(dow_pkg::DAYS_400Y);
                if (d_pos)
                begin
                    alu_sub = 1'b1;
                    if (!alu_flags.neg && !alu_flags.zero)
                    begin
                        d_next = alu_res;
                        y_next = y_reg + W'(dow_pkg::YEARS_400);
                    end
                    else
                        state_next = S_WALK;
                end
                else if (d_reg[W-1])
                begin
                    if (alu_flags.neg || alu_flags.zero)
                    begin
                        d_next = alu_res;
                        y_next = y_reg - W'(dow_pkg::YEARS_400);
                    end
                    else
                        state_next = S_WALK;
                end
                else
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                alu_a = d_reg;
                alu_b = W'(cal_len);
                if (!d_pos)
                begin
                    d_next = alu_res;
                    m_next = m_prev;
                    if (m_reg == dow_pkg::MON_JAN)
                    begin
                        y_next    = y_reg - W'(1);
                        ymod_next = ymod_prev;
                    end
                end
                else
                begin
                    alu_sub = 1'b1;
                    if (!alu_flags.neg && !alu_flags.zero)
                    begin
                        d_next = alu_res;
                        if (m_reg == dow_pkg::MON_DEC)
                        begin
                            m_next    = dow_pkg::MON_JAN;
                            y_next    = y_reg + W'(1);
                            ymod_next = ymod_succ;
                        end
                        else
                            m_next = m_reg + 4'd1;
                    end
                    else
                        state_next = S_ZADJ;
                end
            end
            S_ZADJ:
            begin
                // January and February count in the previous year.
                alu_a      = y_reg;
                alu_b      = (m_reg <= dow_pkg::MON_FEB) ? W'(1) : '0;
                alu_sub    = 1'b1;
                acc_next   = alu_res;
                state_next = S_ZABS;
            end
            S_ZABS, S_WABS:
            begin
                alu_a      = '0;
                alu_b      = acc_reg;
                alu_sub    = 1'b1;
                sgn_next   = acc_reg[W-1];
                acc_next   = acc_reg[W-1] ? alu_res : acc_reg;
                quo_next   = '0;
                state_next = (state_reg == S_ZABS) ? S_DIV : S_MOD;
            end
            S_DIV, S_MOD:
            begin
                // Strip the divisor until the magnitude drops below it:
                // 100 for the century split, 7 for the weekday.
                alu_a   = acc_reg;
                alu_b   = (state_reg == S_DIV) ? W'(dow_pkg::CENTURY) : W'(dow_pkg::WEEK_DAYS);
                alu_sub = 1'b1;
                if (!alu_flags.neg)
                begin
                    acc_next = alu_res;
                    quo_next = quo_reg + W'(1);
                end
                else
                begin
                    rem_next   = acc_reg[7:0];
                    state_next = (state_reg == S_DIV) ? S_P1 : S_DONE;
                end
            end
            S_P1:
            begin
                // Magnitude part: k + k/4 + j/4 - 2j, sign applied afterwards.
                alu_a      = W'(rem_reg);
                alu_b      = W'(rem_reg[7:2]);
                acc_next   = alu_res;
                state_next = S_P2;
            end
            S_P2:
            begin
                alu_a      = acc_reg;
                alu_b      = {2'b00, quo_reg[W-1:2]};
                acc_next   = alu_res;
                state_next = S_P3;
            end
            S_P3:
            begin
                alu_a      = acc_reg;
                alu_b      = {quo_reg[W-2:0], 1'b0};
                alu_sub    = 1'b1;
                acc_next   = alu_res;
                state_next = S_PNEG;
            end
            S_PNEG:
            begin
                alu_a   = '0;
                alu_b   = acc_reg;
                alu_sub = 1'b1;
                if (sgn_reg)
                    acc_next = alu_res;
                state_next = S_PM;
            end
            S_PM:
            begin
                alu_a      = acc_reg;
                alu_b      = W'(dow_pkg::zeller_mterm(m_reg));
                acc_next   = alu_res;
                state_next = S_PD;
            end
            S_PD:
            begin
                alu_a      = acc_reg;
                alu_b      = d_reg;
                acc_next   = alu_res;
                state_next = S_WABS;
            end
            S_DONE:
            begin
                yo_next    = y_reg[14:0];
                mo_next    = m_reg;
                do_next    = d_reg[4:0];
                leap_next  = cal_leap;
                wd_next    = wd_fix;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg    <= y_next;
        m_reg    <= m_next;
        d_reg    <= d_next;
        ymod_reg <= ymod_next;
        acc_reg  <= acc_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        sgn_reg  <= sgn_next;
        off_reg  <= off_next;
        yo_reg   <= yo_next;
        mo_reg   <= mo_next;
        do_reg   <= do_next;
        leap_reg <= leap_next;
        wd_reg   <= wd_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign year_out  = yo_reg;
    assign month_out = mo_reg;
    assign day_out   = do_reg;
    assign leap_flag = leap_reg;
    assign weekday   = wd_reg;

endmodule

`default_nettype wire

// ----- tb/date_offset_weekday_tb.sv -----
// Self-checking testbench for date_offset_weekday: date check, signed day offset,
// month walk, leap flag and weekday. Depends on dow_pkg and the RTL of the block.
`timescale 1ns / 1ps

module date_offset_weekday_tb;

    localparam int     OFF_W       = 16;
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int     TAIL_CYCLES = 1500;
    localparam int     PHASE_JOBS  = 125;
    localparam int     MAX_PRINTS  = 40;

    typedef struct {
        logic [13:0]             year;
        logic [3:0]              month;
        logic [4:0]              day;
        logic signed [OFF_W-1:0] offset;
        int unsigned             idle_pct;
        bit                      drain;
    } date_job_t;

    typedef struct {
        logic signed [14:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic               leap;
        logic [2:0]         wday;
    } date_res_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [13:0]             year_in = '0;
    logic [3:0]              month_in = '0;
    logic [4:0]              day_in = '0;
    logic signed [OFF_W-1:0] day_offset = '0;
    logic                    busy;
    logic                    done;
    logic signed [14:0]      year_out;
    logic [3:0]              month_out;
    logic [4:0]              day_out;
    logic                    leap_flag;
    logic [2:0]              weekday;

    date_job_t queued_jobs[$];
    date_res_t predicted_dates[$];

    int     n_accepted = 0;
    int     n_results = 0;
    int     n_errors = 0;
    int     n_defaulted = 0;
    int     n_leap = 0;
    longint min_year = 1 << 20;
    longint max_year = -(1 << 20);
    longint cycle_count = 0;

    date_offset_weekday #(
        .OFFSET_BITS(OFF_W)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .year_in    (year_in),
        .month_in   (month_in),
        .day_in     (day_in),
        .day_offset (day_offset),
        .busy       (busy),
        .done       (done),
        .year_out   (year_out),
        .month_out  (month_out),
        .day_out    (day_out),
        .leap_flag  (leap_flag),
        .weekday    (weekday)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_leap(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint month_days(longint y, longint m);
        longint len;
        case (m)
            dow_pkg::MON_APR, dow_pkg::MON_JUN,
            dow_pkg::MON_SEP, dow_pkg::MON_NOV: len = 30;
            dow_pkg::MON_FEB:                   len = is_leap(y) ? 29 : 28;
            default:                            len = 31;
        endcase
        return len;
    endfunction

    // Day limit for an incoming date; zero flags a bad month code.
    function automatic longint entry_limit(logic [3:0] m);
        if (m == dow_pkg::MON_FEB)
            return 29;
        if (m >= dow_pkg::MON_JAN && m <= dow_pkg::MON_DEC)
            return month_days(2000, m);
        return 0;
    endfunction

    function automatic bit is_bad_date(logic [13:0] y, logic [3:0] m, logic [4:0] d);
        return (y == 0) || (d == 0) || (d > entry_limit(m));
    endfunction

    function automatic date_res_t shift_date(date_job_t job);
        longint    y;
        longint    m;
        longint    d;
        longint    zy;
        longint    zm;
        longint    j;
        longint    k;
        longint    w;
        date_res_t r;
        y = job.year;
        m = job.month;
        d = job.day;
        if (is_bad_date(job.year, job.month, job.day))
        begin
            y = dow_pkg::DEF_YEAR;
            m = dow_pkg::MON_JAN;
            d = 1;
        end
        d = d + longint'(job.offset);
        while (d > dow_pkg::DAYS_400Y)
        begin
            d = d - dow_pkg::DAYS_400Y;
            y = y + 400;
        end
        while (d <= -dow_pkg::DAYS_400Y)
        begin
            d = d + dow_pkg::DAYS_400Y;
            y = y - 400;
        end
        // borrow from the previous month, then carry into the next
        while (d <= 0)
        begin
            m = m - 1;
            if (m < 1)
            begin
                m = 12;
                y = y - 1;
            end
            d = d + month_days(y, m);
        end
        while (d > month_days(y, m))
        begin
            d = d - month_days(y, m);
            m = m + 1;
            if (m > 12)
            begin
                m = 1;
                y = y + 1;
            end
        end
        // Zeller: January and February count as months 13 and 14 of the prior year
        zy = y;
        zm = m;
        if (m <= 2)
        begin
            zm = m + 12;
            zy = y - 1;
        end
        j = zy / 100;
        k = zy % 100;
        w = k + k / 4 + j / 4 - 2 * j + 26 * (zm + 1) / 10 + d - 1;
        w = w % 7;
        if (w < 0)
            w = w + 7;
        r.year  = 15'(y);
        r.month = 4'(m);
        r.day   = 5'(d);
        r.leap  = is_leap(y);
        r.wday  = 3'(w);
        return r;
    endfunction

    function automatic date_job_t rand_job(int unsigned idle);
        date_job_t   job;
        int unsigned sel;
        longint      lim;
        job.idle_pct = idle;
        job.drain    = ($urandom_range(49) == 0);
        sel = $urandom_range(99);
        if (sel < 6)
            job.year = 14'($urandom_range(4));
        else if (sel < 12)
            job.year = 14'($urandom_range(9999, 9980));
        else
            job.year = 14'($urandom_range(9999, 1));
        if ($urandom_range(15) == 0)
            job.month = 4'($urandom());
        else
            job.month = 4'($urandom_range(12, 1));
        lim = entry_limit(job.month);
        if (lim == 0 || $urandom_range(11) == 0)
            job.day = 5'($urandom_range(31));
        else
            job.day = 5'($urandom_range(lim, 1));
        sel = $urandom_range(9);
        case (sel)
            0, 1, 2: job.offset = OFF_W'($urandom());
            3, 4, 5: job.offset = OFF_W'(int'($urandom_range(800)) - 400);
            6, 7:    job.offset = OFF_W'(int'($urandom_range(6000)) - 3000);
            8:       job.offset = '0;
            default: job.offset = $urandom_range(1) ? OFF_W'(int'($urandom_range(63)) - 32768)
                                                    : OFF_W'(32767 - int'($urandom_range(63)));
        endcase
        return job;
    endfunction

    task automatic add_job(int y, int m, int d, int off);
        date_job_t job;
        job.year     = 14'(y);
        job.month    = 4'(m);
        job.day      = 5'(d);
        job.offset   = OFF_W'(off);
        job.idle_pct = 0;
        job.drain    = 1'b0;
        queued_jobs.push_back(job);
    endtask

    task automatic report_mismatch(string msg);
        if (n_errors < MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        n_errors++;
    endtask

    // Driver: hold a beat while busy, pop it once taken, roll the idle gap otherwise.
    always @(posedge clk or negedge rst_n)
    begin : drive
        bit        taken;
        bit        go;
        date_job_t job;
        date_res_t res;
        if (!rst_n)
        begin
            start      <= 1'b0;
            year_in    <= '0;
            month_in   <= '0;
            day_in     <= '0;
            day_offset <= '0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                job = queued_jobs.pop_front();
                res = shift_date(job);
                predicted_dates.push_back(res);
                n_accepted <= n_accepted + 1;
                if (is_bad_date(job.year, job.month, job.day))
                    n_defaulted++;
                if (res.leap)
                    n_leap++;
            end
            if (!(start && busy))
            begin
                go = 1'b0;
                if (queued_jobs.size() != 0)
                begin
                    go = ($urandom_range(99) >= queued_jobs[0].idle_pct);
                    // drain: hold off until every predicted date has come back
                    if (queued_jobs[0].drain && (taken || n_accepted != n_results))
                        go = 1'b0;
                end
                start <= go;
                if (go)
                begin
                    year_in    <= queued_jobs[0].year;
                    month_in   <= queued_jobs[0].month;
                    day_in     <= queued_jobs[0].day;
                    day_offset <= queued_jobs[0].offset;
                end
            end
        end
    end

    // Monitor: results last one cycle, so capture every done beat.
    always @(posedge clk)
    begin : watch
        date_res_t want;
        if (rst_n && done === 1'b1)
        begin
            n_results <= n_results + 1;
            if ($signed(year_out) < min_year)
                min_year <= $signed(year_out);
            if ($signed(year_out) > max_year)
                max_year <= $signed(year_out);
            if (predicted_dates.size() == 0)
                report_mismatch($sformatf("result %0d-%0d-%0d with nothing pending",
                                          $signed(year_out), month_out, day_out));
            else
            begin
                want = predicted_dates.pop_front();
                if (year_out !== want.year)
                    report_mismatch($sformatf("result %0d year_out %0d, want %0d",
                                              n_results, $signed(year_out), want.year));
                if (month_out !== want.month)
                    report_mismatch($sformatf("result %0d month_out %0d, want %0d",
                                              n_results, month_out, want.month));
                if (day_out !== want.day)
                    report_mismatch($sformatf("result %0d day_out %0d, want %0d",
                                              n_results, day_out, want.day));
                if (leap_flag !== want.leap)
                    report_mismatch($sformatf("result %0d leap_flag %b, want %b",
                                              n_results, leap_flag, want.leap));
                if (weekday !== want.wday)
                    report_mismatch($sformatf("result %0d weekday %0d, want %0d",
                                              n_results, weekday, want.wday));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d dates still pending",
                     cycle_count, predicted_dates.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int unsigned phase_idle[4];
        date_job_t   job;
        phase_idle = '{0, 70, 26, 0};

        // directed: field extremes, bad dates, leap rules, year edges
        add_job(1970, 1, 1, 0);
        add_job(2024, 2, 29, 0);
        add_job(2023, 2, 29, 0);
        add_job(2023, 2, 30, 5);
        add_job(0, 6, 15, 10);
        add_job(2000, 0, 10, 0);
        add_job(2000, 13, 10, 0);
        add_job(9999, 15, 31, -1);
        add_job(2001, 5, 0, 3);
        add_job(2001, 4, 31, 0);
        add_job(2000, 1, 31, 0);
        add_job(2000, 3, 31, 0);
        add_job(1999, 12, 31, 1);
        add_job(2000, 3, 1, -1);
        add_job(1900, 3, 1, -1);
        add_job(2100, 2, 28, 1);
        add_job(2000, 2, 28, 1);
        add_job(1, 1, 1, -1);
        add_job(1, 1, 1, -32768);
        add_job(1, 1, 1, 32767);
        add_job(9999, 12, 31, 32767);
        add_job(9999, 12, 31, -32768);
        add_job(16383, 1, 1, 0);
        add_job(8191, 7, 16, 21845);

        for (int p = 0; p < 4; p++)
            for (int i = 0; i < PHASE_JOBS; i++)
            begin
                job = rand_job(phase_idle[p]);
                if (i == 0)
                    job.drain = 1'b1;
                queued_jobs.push_back(job);
            end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (queued_jobs.size() != 0 || n_results != n_accepted)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        while (predicted_dates.size() != 0)
        begin
            report_mismatch($sformatf("date %0d-%0d-%0d never came back",
                                      predicted_dates[0].year, predicted_dates[0].month,
                                      predicted_dates[0].day));
            void'(predicted_dates.pop_front());
        end

        $display("%0d dates shifted, %0d bad inputs forced to 1900-01-01, %0d leap results",
                 n_accepted, n_defaulted, n_leap);
        $display("result years spanned %0d..%0d over %0d cycles with four idle phases",
                 min_year, max_year, cycle_count);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
